[hw/rtl/mbpm_pkg.sv]
// shared types and constants for the masked byte pattern matcher
package mbpm_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_PATTERN_LOW  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PATTERN_HIGH = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_CARE_LOW     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_CARE_HIGH    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_PATTERN_LEN  = 3'd4;

  // fixed register and field widths
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned LenRegW    = 5;
  localparam int unsigned RegBytes   = 16;
  localparam int unsigned MatchStartW = 32;

  // per-cell compare setup: pattern byte and care mask
  typedef struct packed {
    logic [7:0] pattern;
    logic [7:0] care;
  } cell_cfg_t;

endpackage

[hw/rtl/mbpm_cell.sv]
// one window cell: holds a byte, hands it on, compares its incoming byte
module mbpm_cell
  import mbpm_pkg::*;
(
  input  logic      clk_i,
  input  logic      shift_i,
  input  logic [7:0] byte_i,
  input  cell_cfg_t cfg_i,
  output logic [7:0] byte_o,
  output logic      hit_o
);

  logic [7:0] byte_q;
  logic [7:0] byte_d;

  // window byte moves one cell on per accepted item
  assign byte_d = byte_i;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

  // masked compare on the byte this cell holds after the shift
  assign hit_o = (((byte_i ^ cfg_i.pattern) & cfg_i.care) == 8'h00);

endmodule

[hw/rtl/masked_byte_pattern_matcher.sv]
// top level of the masked byte pattern matcher: config, cell chain, result register
//
// channel   direction  handshake                 payload
// in        input      in_valid_i / in_stall_o   data_byte_i, final_byte_i
// out       output     out_valid_o / out_stall_i match_found_o, match_start_o
// cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// one item per cycle unless the input stalls; the result is in the output register
// in the cycle after it is taken, set by the combinational masked compare of the cell row.
// reset clears config, fill count, offset and the output valid; window bytes are
// not reset since the fill count keeps stale bytes out of every compare.
// the input stalls only while a result waits and the output is stalled.
module masked_byte_pattern_matcher
  import mbpm_pkg::*;
#(
  parameter int unsigned PATTERN_BYTES = 16,
  parameter int unsigned OFFSET_BITS   = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             data_byte_i,
  input  logic                   final_byte_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   match_found_o,
  output logic [MatchStartW-1:0] match_start_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxW-1:0]     cfg_index_i,
  input  logic [CfgDataW-1:0]    cfg_data_i
);

  localparam int unsigned LenW = $clog2(PATTERN_BYTES + 1);
  localparam int unsigned CmpW = (LenW > LenRegW) ? LenW : LenRegW;
  localparam int unsigned ExtW = (OFFSET_BITS > MatchStartW) ? OFFSET_BITS : MatchStartW;
  localparam logic [CmpW-1:0] PatBytesC = CmpW'(PATTERN_BYTES);
  localparam logic [CmpW-1:0] RegBytesC = CmpW'(RegBytes);
  localparam logic [LenW-1:0] FillMaxC  = LenW'(PATTERN_BYTES);

  logic [CfgDataW-1:0] pat_lo_q, pat_hi_q, care_lo_q, care_hi_q;
  logic [LenRegW-1:0]  len_q;
  logic [LenW-1:0]     fill_q, fill_d;
  logic [OFFSET_BITS-1:0] offset_q, offset_d;
  logic                out_valid_q, found_q;
  logic [MatchStartW-1:0] start_q;

  logic                in_accept;
  logic [CmpW-1:0]     len_raw, eff_len;
  logic [LenW-1:0]     fill_nxt;
  logic                window_full, hit;
  logic [OFFSET_BITS-1:0] start_off;
  logic [ExtW-1:0]     start_ext;

  logic [7:0]          pat_bytes  [RegBytes];
  logic [7:0]          care_bytes [RegBytes];
  logic [7:0]          win        [PATTERN_BYTES];
  logic [PATTERN_BYTES-1:0] hits;

  // configuration writes, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q  <= '0;
      pat_hi_q  <= '0;
      care_lo_q <= '0;
      care_hi_q <= '0;
      len_q     <= LenRegW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_PATTERN_LOW:  pat_lo_q  <= cfg_data_i;
        REG_PATTERN_HIGH: pat_hi_q  <= cfg_data_i;
        REG_CARE_LOW:     care_lo_q <= cfg_data_i;
        REG_CARE_HIGH:    care_hi_q <= cfg_data_i;
        REG_PATTERN_LEN:  len_q     <= cfg_data_i[LenRegW-1:0];
        default: ;
      endcase
    end
  end

  // split pattern and mask registers into bytes
  for (genvar i = 0; i < RegBytes; i++) begin : g_bytes
    if (i < 8) begin : g_lo
      assign pat_bytes[i]  = pat_lo_q[i*8 +: 8];
      assign care_bytes[i] = care_lo_q[i*8 +: 8];
    end else begin : g_hi
      assign pat_bytes[i]  = pat_hi_q[(i-8)*8 +: 8];
      assign care_bytes[i] = care_hi_q[(i-8)*8 +: 8];
    end
  end

  // effective pattern length, clamped to 1..PATTERN_BYTES
  assign len_raw = CmpW'(len_q);
  always_comb begin
    if (len_raw == '0) begin
      eff_len = CmpW'(1);
    end else if (len_raw > PatBytesC) begin
      eff_len = PatBytesC;
    end else begin
      eff_len = len_raw;
    end
  end

  // handshake: output register parts the two sides
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  // cell row; cell k sees the byte received k items ago
  for (genvar k = 0; k < PATTERN_BYTES; k++) begin : g_cell
    logic [CmpW-1:0] pat_idx;
    logic            in_use;
    cell_cfg_t       cell_cfg;
    logic [7:0]      cell_in;

    assign in_use  = CmpW'(k) < eff_len;
    assign pat_idx = eff_len - CmpW'(1) - CmpW'(k);

    always_comb begin
      cell_cfg.pattern = 8'h00;
      cell_cfg.care    = 8'h00;
      if (in_use && (pat_idx < RegBytesC)) begin
        cell_cfg.pattern = pat_bytes[pat_idx[3:0]];
        cell_cfg.care    = care_bytes[pat_idx[3:0]];
      end
    end

    if (k == 0) begin : g_head
      assign cell_in = data_byte_i;
    end else begin : g_body
      assign cell_in = win[k-1];
    end

    mbpm_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (in_accept),
      .byte_i  (cell_in),
      .cfg_i   (cell_cfg),
      .byte_o  (win[k]),
      .hit_o   (hits[k])
    );
  end

  // fill count and match decision
  assign fill_nxt    = (fill_q == FillMaxC) ? fill_q : fill_q + LenW'(1);
  assign window_full = CmpW'(fill_nxt) >= eff_len;
  assign hit         = window_full && (&hits);

  // start offset, wrapped to the offset width then cut to the port
  assign start_off = offset_q - OFFSET_BITS'(eff_len - CmpW'(1));
  assign start_ext = ExtW'(start_off);

  // buffer position state
  always_comb begin
    fill_d   = fill_q;
    offset_d = offset_q;
    if (in_accept) begin
      if (final_byte_i) begin
        fill_d   = '0;
        offset_d = '0;
      end else begin
        fill_d   = fill_nxt;
        offset_d = offset_q + OFFSET_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      offset_q <= '0;
    end else begin
      fill_q   <= fill_d;
      offset_q <= offset_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      found_q <= hit;
      start_q <= hit ? start_ext[MatchStartW-1:0] : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign match_found_o = found_q;
  assign match_start_o = start_q;

`ifndef SYNTHESIS
  // final byte clears the buffer position
  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && final_byte_i |=> (fill_q == '0) && (offset_q == '0))
    else $error("buffer position not cleared after final byte");

  // offset steps by one on an ordinary byte
  a_offset_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && !final_byte_i |=> offset_q == $past(offset_q) + OFFSET_BITS'(1))
    else $error("offset did not advance");

  // fill count never passes the window depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillMaxC)
    else $error("fill count overflow");

  // no match means a zero start offset
  a_nomatch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !match_found_o |-> match_start_o == '0)
    else $error("start offset set without a match");
`endif

endmodule
